// ===== design/bfsk_pkg.sv =====
// Shared constants, types and hash helpers for the Bloom filter over string keys.
// No dependencies; imported by every module of the block.
package bfsk_pkg;

    // Store geometry
    localparam int MAX_BITS  = 1024;
    localparam int POS_W     = $clog2(MAX_BITS);
    localparam int MOD_W     = $clog2(MAX_BITS + 1);
    localparam int ROW_BITS  = 8;
    localparam int BIT_W     = $clog2(ROW_BITS);
    localparam int DEPTH     = (MAX_BITS + ROW_BITS - 1) / ROW_BITS;
    localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Hashing and configuration
    localparam int HASH_W    = 64;
    localparam int NUM_HASH  = 3;
    localparam int CNT_W     = $clog2(HASH_W);
    localparam int CFG_W     = 11;
    localparam logic [CFG_W-1:0] CFG_RESET = 11'd100;

    // Key-end queue between front and back
    localparam int QDEPTH    = 2;
    localparam int QA_W      = $clog2(QDEPTH);
    localparam int QC_W      = $clog2(QDEPTH + 1);

    // Operation codes
    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // One finished key: operation and the three raw hashes
    typedef struct packed {
        logic              op;
        logic [HASH_W-1:0] ha;
        logic [HASH_W-1:0] hb;
        logic [HASH_W-1:0] hc;
    } t_key_end;

    // h * 11 + b
    function automatic logic [HASH_W-1:0] hash_step_a(input logic [HASH_W-1:0] h,
                                                      input logic [7:0] b);
        return (h << 3) + (h << 1) + h + {{(HASH_W-8){1'b0}}, b};
    endfunction

    // h * 17 + b
    function automatic logic [HASH_W-1:0] hash_step_b(input logic [HASH_W-1:0] h,
                                                      input logic [7:0] b);
        return (h << 4) + h + {{(HASH_W-8){1'b0}}, b};
    endfunction

    // h * 23 + b
    function automatic logic [HASH_W-1:0] hash_step_c(input logic [HASH_W-1:0] h,
                                                      input logic [7:0] b);
        return (h << 4) + (h << 2) + (h << 1) + h + {{(HASH_W-8){1'b0}}, b};
    endfunction

endpackage

// ===== design/bloom_filter_string_keys.sv =====
// Top level of the Bloom filter over string keys: filter size register and wiring.
// Depends on bfsk_pkg, bfsk_front, bfsk_queue and bfsk_back.
//
// Use: key bytes arrive on the s-channel, one per request, key_byte in tdata,
// opcode (0 add, 1 query) in tuser and the last marker in tlast; only the opcode
// of the last byte counts. Each key end yields one result on the m-channel:
// was_query in tuser, maybe_present in tdata bit 0 (always 0 for an add).
// The filter size is written through the cfg channel (always ready); a value
// of 0 acts as 1 and values above 1024 saturate. It is read when a key is
// processed, so write it only while no key is in flight.
// Throughput: key bytes are taken one per cycle while tready is high. Each key end
// occupies the back end while it is taken from the queue, reduced by the bit-serial
// modulo of the three 64-bit hashes, applied by the single-port store accesses (a read
// and an update per hash) and posted; the next key is taken only after that. A
// two-entry queue lets the next keys stream in meanwhile; tready drops when full.
// Reset: the store is cleared one row per cycle, all 128 rows, with tready low.
// A stalled receiver holds the result; the back end then waits before posting.
module bloom_filter_string_keys (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // key bytes
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [7:0]                  i_s_tdata,   // [7:0] key_byte
    input  logic                        i_s_tuser,   // [0] opcode
    input  logic                        i_s_tlast,
    // results
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [7:0]                  o_m_tdata,   // [0] maybe_present, [7:1] zero
    output logic                        o_m_tuser,   // [0] was_query
    // filter size register
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [bfsk_pkg::CFG_W-1:0]  i_cfg_data
);
    import bfsk_pkg::*;

    logic [CFG_W-1:0] r_filter_bits;
    logic             w_clear_done;
    logic             w_q_full, w_q_empty, w_q_push, w_q_pop;
    t_key_end         w_push_data, w_pop_data;
    logic             w_maybe_present;

    // Hold the filter size register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_bits <= CFG_RESET;
        end else if (i_cfg_valid) begin
            r_filter_bits <= i_cfg_data;
        end
    end

    bfsk_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .o_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_s_tlast    (i_s_tlast),
        .i_clear_done (w_clear_done),
        .i_q_full     (w_q_full),
        .o_q_push     (w_q_push),
        .o_q_data     (w_push_data)
    );

    bfsk_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_q_push),
        .i_push_data (w_push_data),
        .i_pop       (w_q_pop),
        .o_pop_data  (w_pop_data),
        .o_full      (w_q_full),
        .o_empty     (w_q_empty)
    );

    bfsk_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_filter_bits   (r_filter_bits),
        .i_q_empty       (w_q_empty),
        .i_q_data        (w_pop_data),
        .o_q_pop         (w_q_pop),
        .o_clear_done    (w_clear_done),
        .o_m_tvalid      (o_m_tvalid),
        .i_m_tready      (i_m_tready),
        .o_was_query     (o_m_tuser),
        .o_maybe_present (w_maybe_present)
    );

    assign o_m_tdata = {7'b0, w_maybe_present};

endmodule

// ===== design/bfsk_front.sv =====
// Front end: accepts key bytes and keeps the three running hashes.
// Depends on bfsk_pkg; pushes each finished key into bfsk_queue.
module bfsk_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [7:0]          i_s_tdata,   // [7:0] key_byte
    input  logic                i_s_tuser,   // [0] opcode
    input  logic                i_s_tlast,
    input  logic                i_clear_done,
    input  logic                i_q_full,
    output logic                o_q_push,
    output bfsk_pkg::t_key_end  o_q_data
);
    import bfsk_pkg::*;

    logic [HASH_W-1:0] r_ha, r_hb, r_hc;
    logic [HASH_W-1:0] n_ha, n_hb, n_hc;
    logic              w_accept;

    // Take bytes once the store is cleared and the queue has room
    assign o_s_tready = i_clear_done && !i_q_full;
    assign w_accept   = i_s_tvalid && o_s_tready;

    // Advance the hashes by one byte
    assign n_ha = hash_step_a(r_ha, i_s_tdata);
    assign n_hb = hash_step_b(r_hb, i_s_tdata);
    assign n_hc = hash_step_c(r_hc, i_s_tdata);

    // Hand the finished key to the queue
    assign o_q_push    = w_accept && i_s_tlast;
    assign o_q_data.op = i_s_tuser;
    assign o_q_data.ha = n_ha;
    assign o_q_data.hb = n_hb;
    assign o_q_data.hc = n_hc;

    // Hold the running hashes; restart them after each key end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ha <= '0;
            r_hb <= '0;
            r_hc <= '0;
        end else if (w_accept) begin
            if (i_s_tlast) begin
                r_ha <= '0;
                r_hb <= '0;
                r_hc <= '0;
            end else begin
                r_ha <= n_ha;
                r_hb <= n_hb;
                r_hc <= n_hc;
            end
        end
    end

endmodule

// ===== design/bfsk_queue.sv =====
// Short queue of finished keys between the front and back ends.
// Depends on bfsk_pkg for the entry type and depth.
module bfsk_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  bfsk_pkg::t_key_end  i_push_data,
    input  logic                i_pop,
    output bfsk_pkg::t_key_end  o_pop_data,
    output logic                o_full,
    output logic                o_empty
);
    import bfsk_pkg::*;

    t_key_end          r_slot [QDEPTH];
    logic [QA_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [QC_W-1:0]   r_count;
    logic              w_push, w_pop;

    assign o_full     = (r_count == QC_W'(QDEPTH));
    assign o_empty    = (r_count == '0);
    assign w_push     = i_push && !o_full;
    assign w_pop      = i_pop && !o_empty;
    assign o_pop_data = r_slot[r_rd_ptr];

    // Store the pushed entry
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= i_push_data;
        end
    end

    // Advance pointers and the fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == QA_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == QA_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== design/bfsk_back.sv =====
// Back end: reduces the hashes modulo the filter size bit by bit, then sets or
// tests the three store bits. Holds the bit store and its clearing pass. Uses bfsk_pkg.
module bfsk_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [bfsk_pkg::CFG_W-1:0]  i_filter_bits,
    input  logic                        i_q_empty,
    input  bfsk_pkg::t_key_end          i_q_data,
    output logic                        o_q_pop,
    output logic                        o_clear_done,
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic                        o_was_query,
    output logic                        o_maybe_present
);
    import bfsk_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_RD,
        S_UPD,
        S_FIN
    } t_state;

    t_state             r_state;
    logic [HASH_W-1:0]  r_h   [NUM_HASH];
    logic [MOD_W-1:0]   r_rem [NUM_HASH];
    logic [MOD_W-1:0]   n_rem [NUM_HASH];
    logic [MOD_W-1:0]   r_mod;
    logic [MOD_W-1:0]   w_mod;
    logic [CNT_W-1:0]   r_cnt;
    logic [1:0]         r_sel;
    logic               r_op;
    logic               r_hit;
    logic [ADDR_W-1:0]  r_clr_addr;
    logic               r_out_valid, r_out_query, r_out_hit;

    // Bit store, one byte per row
    logic [ROW_BITS-1:0] r_store [DEPTH];
    logic [ROW_BITS-1:0] r_rdata;
    logic [MOD_W-1:0]    w_pos;
    logic [ADDR_W-1:0]   w_row;
    logic [BIT_W-1:0]    w_bit;
    logic [ROW_BITS-1:0] w_mask;
    logic                w_rd_en, w_wr_en;
    logic [ADDR_W-1:0]   w_wr_addr;
    logic [ROW_BITS-1:0] w_wr_data;

    // Clamp the configured size into 1 .. MAX_BITS
    always_comb begin
        if (i_filter_bits == '0) begin
            w_mod = MOD_W'(1);
        end else if (32'(i_filter_bits) > MAX_BITS) begin
            w_mod = MOD_W'(MAX_BITS);
        end else begin
            w_mod = MOD_W'(i_filter_bits);
        end
    end

    // One restoring remainder step per hash: shift in the next bit, subtract if fits
    always_comb begin
        logic [MOD_W:0] t;
        for (int k = 0; k < NUM_HASH; k++) begin
            t = {r_rem[k], r_h[k][HASH_W-1]};
            if (t >= {1'b0, r_mod}) begin
                t = t - {1'b0, r_mod};
            end
            n_rem[k] = t[MOD_W-1:0];
        end
    end

    // Address of the bit currently handled
    assign w_pos  = r_rem[r_sel];
    assign w_row  = ADDR_W'(w_pos >> BIT_W);
    assign w_bit  = w_pos[BIT_W-1:0];
    assign w_mask = ROW_BITS'(1) << w_bit;

    // Store port control: clearing pass or read-modify-write of an add
    assign w_rd_en   = (r_state == S_RD);
    assign w_wr_en   = (r_state == S_CLEAR) || (r_state == S_UPD && r_op == OP_ADD);
    assign w_wr_addr = (r_state == S_CLEAR) ? r_clr_addr : w_row;
    assign w_wr_data = (r_state == S_CLEAR) ? '0 : (r_rdata | w_mask);

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_store[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rdata <= r_store[w_row];
        end
    end

    assign o_q_pop         = (r_state == S_IDLE) && !i_q_empty;
    assign o_clear_done    = (r_state != S_CLEAR);
    assign o_m_tvalid      = r_out_valid;
    assign o_was_query     = r_out_query;
    assign o_maybe_present = r_out_hit;

    // Sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_sel       <= '0;
        end else begin
            // drop the result once taken, unless a new one is posted in its place
            if (r_out_valid && i_m_tready && r_state != S_FIN) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (!i_q_empty) begin
                        r_op    <= i_q_data.op;
                        r_h[0]  <= i_q_data.ha;
                        r_h[1]  <= i_q_data.hb;
                        r_h[2]  <= i_q_data.hc;
                        r_mod   <= w_mod;
                        r_cnt   <= '0;
                        for (int k = 0; k < NUM_HASH; k++) begin
                            r_rem[k] <= '0;
                        end
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    for (int k = 0; k < NUM_HASH; k++) begin
                        r_rem[k] <= n_rem[k];
                        r_h[k]   <= r_h[k] << 1;
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(HASH_W - 1)) begin
                        r_sel   <= '0;
                        r_hit   <= 1'b1;
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    if (r_op == OP_QUERY) begin
                        r_hit <= r_hit & r_rdata[w_bit];
                    end
                    if (r_sel == 2'(NUM_HASH - 1)) begin
                        r_state <= S_FIN;
                    end else begin
                        r_sel   <= r_sel + 1'b1;
                        r_state <= S_RD;
                    end
                end
                S_FIN: begin
                    if (!r_out_valid || i_m_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_query <= r_op;
                        r_out_hit   <= (r_op == OP_QUERY) && r_hit;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // An add never reports a hit
    a_add_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_query) |-> !r_out_hit)
        else $error("add result reports a hit");

    // Remainders stay below the modulus while dividing
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem[0] < r_mod && r_rem[1] < r_mod && r_rem[2] < r_mod))
        else $error("remainder out of range");

    // A waiting result is not overwritten
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_tready) |=>
        (r_out_valid && $stable(r_out_query) && $stable(r_out_hit)))
        else $error("pending result overwritten");

    // Keys are taken from the queue only when the sequencer is free
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> (r_state == S_DIV))
        else $error("queue popped outside idle");

    // The clearing pass ends only after the last row
    a_clear_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR && r_clr_addr != ADDR_W'(DEPTH - 1)) |=> (r_state == S_CLEAR))
        else $error("clearing pass ended early");

endmodule

// ===== sim/testbench.sv =====
// Self-checking bench for bloom_filter_string_keys: streams string keys, predicts each
// add/query answer from its own copy of the hashes and bit store, and checks every result.
// Depends on bfsk_pkg and the design top only.
`timescale 1ns / 100ps

module testbench;
    import bfsk_pkg::*;

    localparam int KEY_MAX        = 24;    // longest key the stimulus builds
    localparam int HOLD_CYCLES    = 600;   // long receiver hold-off
    localparam int SETTLE_CYCLES  = 90;    // back end latency plus margin
    localparam int WATCHDOG_LIMIT = 6000;  // cycles with no request moved
    localparam int PRINT_CAP      = 100;

    typedef struct packed {
        logic was_query;
        logic maybe_present;
    } t_answer;

    // Tracks hashes, filter size and bit store; holds answers still owed by the block
    class filter_tracker;
        logic [63:0]         hash_x11;
        logic [63:0]         hash_x17;
        logic [63:0]         hash_x23;
        logic [MAX_BITS-1:0] filter_store;
        logic [CFG_W-1:0]    size_reg;
        t_answer             answers_due[$];
        int                  errors;

        function new();
            hash_x11     = '0;
            hash_x17     = '0;
            hash_x23     = '0;
            filter_store = '0;
            size_reg     = CFG_RESET;
            errors       = 0;
        endfunction

        function void set_size(logic [CFG_W-1:0] value);
            size_reg = value;
        endfunction

        function int pending();
            return answers_due.size();
        endfunction

        // Fold one key byte into the hashes; at key end look up or set the three bits
        function void note_key_byte(logic op, logic [7:0] kb, logic last);
            logic [63:0] m;
            int          pa, pb, pc;
            t_answer     due;
            hash_x11 = hash_x11 * 64'd11 + 64'(kb);
            hash_x17 = hash_x17 * 64'd17 + 64'(kb);
            hash_x23 = hash_x23 * 64'd23 + 64'(kb);
            if (!last) return;
            // zero size acts as one, oversized saturates
            if (size_reg == '0) begin
                m = 64'd1;
            end else if (size_reg > MAX_BITS) begin
                m = 64'(MAX_BITS);
            end else begin
                m = 64'(size_reg);
            end
            pa = int'(hash_x11 % m);
            pb = int'(hash_x17 % m);
            pc = int'(hash_x23 % m);
            due.was_query     = op;
            due.maybe_present = 1'b0;
            if (op == OP_ADD) begin
                filter_store[pa] = 1'b1;
                filter_store[pb] = 1'b1;
                filter_store[pc] = 1'b1;
            end else begin
                due.maybe_present = filter_store[pa] & filter_store[pb] & filter_store[pc];
            end
            answers_due.push_back(due);
            hash_x11 = '0;
            hash_x17 = '0;
            hash_x23 = '0;
        endfunction

        task report(string msg);
            if (errors < PRINT_CAP) $display("mismatch: %s", msg);
            errors++;
        endtask

        // Compare one delivered result with the oldest answer owed
        task check_answer(logic tuser, logic [7:0] tdata);
            t_answer due;
            if (answers_due.size() == 0) begin
                report($sformatf("result with none owed: was_query=%0b maybe_present=%0b",
                                 tuser, tdata[0]));
                return;
            end
            due = answers_due.pop_front();
            if (tuser !== due.was_query)
                report($sformatf("was_query %0b, predicted %0b", tuser, due.was_query));
            if (tdata[0] !== due.maybe_present)
                report($sformatf("maybe_present %0b, predicted %0b (was_query %0b)",
                                 tdata[0], due.maybe_present, due.was_query));
        endtask
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_s_tvalid;
    logic               o_s_tready;
    logic [7:0]         i_s_tdata;   // [7:0] key_byte
    logic               i_s_tuser;   // [0] opcode
    logic               i_s_tlast;
    logic               o_m_tvalid;
    logic               i_m_tready;
    logic [7:0]         o_m_tdata;   // [0] maybe_present, [7:1] zero
    logic               o_m_tuser;   // [0] was_query
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [CFG_W-1:0]   i_cfg_data;

    filter_tracker      sb;
    int                 send_idle_pct;
    int                 recv_idle_pct;
    bit                 hold_req;
    int                 stall_cycles;
    logic [8*KEY_MAX-1:0] known_keys[$];
    int                 known_lens[$];

    bloom_filter_string_keys dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // 10 ns clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Observe every handshake at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) sb.set_size(i_cfg_data);
            if (i_s_tvalid && o_s_tready) sb.note_key_byte(i_s_tuser, i_s_tdata, i_s_tlast);
            if (o_m_tvalid && i_m_tready) sb.check_answer(o_m_tuser, o_m_tdata);
        end
    end

    // Abort when no request moves for too long
    initial stall_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Result side: random back-pressure, plus one long hold-off on request
    initial begin
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req   = 1'b0;
                i_m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            i_m_tready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Offer one key byte, idling at random first; returns at the falling edge after acceptance
    task automatic send_byte(input logic op, input logic [7:0] kb, input logic last);
        logic done;
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid = 1'b0;
            i_s_tdata  = 8'($urandom);
            i_s_tuser  = 1'($urandom);
            i_s_tlast  = 1'($urandom);
            @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tdata  = kb;
        i_s_tuser  = op;
        i_s_tlast  = last;
        done = 1'b0;
        while (!done) begin
            @(posedge i_clk);
            done = o_s_tready;
            @(negedge i_clk);
        end
        i_s_tvalid = 1'b0;
    endtask

    // Send a whole key, first byte in the lowest bits; lead_ops gives opcodes of non-final bytes
    task automatic send_key(input logic [8*KEY_MAX-1:0] bytes, input int len,
                            input logic op, input logic [KEY_MAX-1:0] lead_ops);
        for (int i = 0; i < len; i++) begin
            if (i == len - 1) send_byte(op, bytes[8*i +: 8], 1'b1);
            else send_byte(lead_ops[i], bytes[8*i +: 8], 1'b0);
        end
    endtask

    task automatic write_filter_bits(input logic [CFG_W-1:0] value);
        logic done;
        i_cfg_valid = 1'b1;
        i_cfg_data  = value;
        done = 1'b0;
        while (!done) begin
            @(posedge i_clk);
            done = o_cfg_ready;
            @(negedge i_clk);
        end
        i_cfg_valid = 1'b0;
    endtask

    // Wait for every owed answer, then let the back end drain
    task automatic settle();
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Random keys: repeats of known keys to reach hits, fresh keys as noise
    task automatic run_random(input int n_bytes);
        int                   sent;
        int                   len;
        int                   pick;
        logic                 op;
        logic [8*KEY_MAX-1:0] bytes;
        sent = 0;
        while (sent < n_bytes) begin
            op = ($urandom_range(99) < 45) ? OP_ADD : OP_QUERY;
            if (known_keys.size() != 0 && $urandom_range(99) < 45) begin
                pick  = $urandom_range(known_keys.size() - 1);
                bytes = known_keys[pick];
                len   = known_lens[pick];
            end else begin
                // mostly short keys, a few long enough to wrap the hashes
                len   = ($urandom_range(99) < 8) ? $urandom_range(KEY_MAX, 15)
                                                 : $urandom_range(6, 1);
                bytes = '0;
                for (int i = 0; i < len; i++) bytes[8*i +: 8] = 8'($urandom_range(255, 1));
                if (op == OP_ADD) begin
                    known_keys.push_back(bytes);
                    known_lens.push_back(len);
                    if (known_keys.size() > 48) begin
                        void'(known_keys.pop_front());
                        void'(known_lens.pop_front());
                    end
                end
            end
            send_key(bytes, len, op, KEY_MAX'($urandom));
            sent += len;
        end
    endtask

    initial begin
        logic [CFG_W-1:0] sizes[6];
        sb            = new();
        hold_req      = 1'b0;
        send_idle_pct = 8;
        recv_idle_pct = 73;
        i_rst_n       = 1'b0;
        i_s_tvalid    = 1'b0;
        i_s_tdata     = '0;
        i_s_tuser     = 1'b0;
        i_s_tlast     = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        sizes = '{11'd1024, 11'd1, 11'd100, 11'd513, 11'd7, 11'd1023};
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed keys at the reset size: byte extremes, hit and miss, ignored lead opcodes
        send_key(192'h01, 1, OP_ADD, '0);
        send_key(192'h01, 1, OP_QUERY, '0);
        send_key(192'hFF, 1, OP_QUERY, '0);
        send_key(192'h0180FF, 3, OP_ADD, '1);
        send_key(192'h0180FF, 3, OP_QUERY, '0);
        send_key(192'hAA55, 2, OP_QUERY, '1);

        // Zero size behaves as one
        settle();
        write_filter_bits(11'd0);
        send_key(192'h7F, 1, OP_ADD, '0);
        send_key(192'h80, 1, OP_QUERY, '0);

        // Oversized size saturates; store survives size writes
        settle();
        write_filter_bits(11'd2047);
        send_key(192'hF00F, 2, OP_ADD, '0);
        send_key(192'hF00F, 2, OP_QUERY, '1);
        settle();
        write_filter_bits(11'd1024);
        send_key(192'hF00F, 2, OP_QUERY, '0);
        settle();
        write_filter_bits(11'd1);
        send_key(192'h33, 1, OP_QUERY, '0);

        // Random segments: sender lightly idle, then receiver lightly idle, then none
        for (int seg = 0; seg < 6; seg++) begin
            settle();
            if (seg == 2) begin
                send_idle_pct = 73;
                recv_idle_pct = 8;
            end else if (seg == 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_filter_bits(sizes[seg]);
            if (seg == 4) hold_req = 1'b1;
            run_random(150);
        end

        settle();
        if (sb.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/bfsk_pkg.sv
design/bfsk_front.sv
design/bfsk_queue.sv
design/bfsk_back.sv
design/bloom_filter_string_keys.sv
sim/testbench.sv
